### hw/rtl/fsbs_pkg.sv
// Shared widths, types and constants for the flow shop backtracking scheduler.
package fsbs_pkg;

  localparam int TIME_W  = 10;
  localparam int SPAN_W  = 16;
  localparam int INDEX_W = 3;

  localparam logic [SPAN_W-1:0] BOUND_RESET = 16'd1000;

  typedef struct packed {
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] second;
  } job_t;

  typedef struct packed {
    logic [SPAN_W-1:0] f1;
    logic [SPAN_W-1:0] f2;
  } finish_t;

endpackage

### hw/rtl/flow_shop_backtrack_scheduler.sv
// Two-machine flow shop scheduler: job loading, depth-first search, result streaming.
//
// Jobs are loaded one word per cycle, while the block is idle, into a job memory; the
// word with in_last_job set starts an exhaustive depth-first search over job orders,
// pruned against the best makespan so far (starting at the cfg bound, strictly-less
// wins, first minimum kept). The search is driven by one evaluation unit in front of
// two synchronous memories (job times, per-level finish times): each tried candidate
// is a job read, then an evaluation; a candidate already in the partial order is
// skipped; and each step back up a level is a finish-time read, then a reload. Pruning
// usually cuts a search far short of the full tree. Results then stream at one word
// per cycle while out_ready is high: the best order, one job index per word, or a
// single word with out_found low when nothing beats the bound. The input is held off
// from the last job until the last result is registered; the final result may still
// wait at the output while the next set loads.
module flow_shop_backtrack_scheduler
  import fsbs_pkg::*;
#(
  parameter int MAX_JOBS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SPAN_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TIME_W-1:0]  in_first_time,
  input  logic [TIME_W-1:0]  in_second_time,
  input  logic               in_last_job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_job_index,
  output logic [SPAN_W-1:0]  out_best_makespan,
  output logic               out_found,
  output logic               out_overflow,
  output logic               out_last_result
);

  localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_BT   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // memories
  job_t    job_mem [MAX_JOBS];
  finish_t lev_mem [MAX_JOBS];
  job_t    job_rd_r;
  finish_t lev_rd_r;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [SPAN_W-1:0]   bound_r;
  logic [SPAN_W-1:0]   best_r, best_nxt;
  logic                found_r, found_nxt;
  logic [JW-1:0]       lvl_r, lvl_nxt;
  logic [CW-1:0]       cand_r, cand_nxt;
  logic [MAX_JOBS-1:0] used_r, used_nxt;
  logic [SPAN_W-1:0]   base_f1_r, base_f1_nxt;
  logic [SPAN_W-1:0]   base_f2_r, base_f2_nxt;
  logic [JW-1:0]       oidx_r, oidx_nxt;
  logic [JW-1:0]       choice_r [MAX_JOBS];
  logic [JW-1:0]       order_r [MAX_JOBS];

  logic                out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]  out_idx_r;
  logic [SPAN_W-1:0]   out_span_r;
  logic                out_found_r;
  logic                out_ovf_r;
  logic                out_last_r;

  logic                job_we;
  logic                lev_we;
  logic [JW-1:0]       lev_wa;
  finish_t             lev_wd;
  logic                choose;
  logic                save;
  logic                do_back;
  logic                out_load;
  logic                out_last_nxt;
  logic [INDEX_W-1:0]  out_idx_nxt;

  logic [SPAN_W-1:0]   f1, f2, f2_start;
  logic                hit;
  logic                last_lvl;
  logic [JW-1:0]       prev_choice;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  assign out_valid         = out_valid_r;
  assign out_job_index     = out_idx_r;
  assign out_best_makespan = out_span_r;
  assign out_found         = out_found_r;
  assign out_overflow      = out_ovf_r;
  assign out_last_result   = out_last_r;

  // one extension step: f1' = f1 + a, f2' = max(f1', f2) + b
  always_comb begin
    f1       = base_f1_r + SPAN_W'(job_rd_r.first);
    f2_start = (f1 > base_f2_r) ? f1 : base_f2_r;
    f2       = f2_start + SPAN_W'(job_rd_r.second);
    hit      = (f2 < best_r);
    last_lvl = ((CW'(lvl_r) + CW'(1)) == count_r);
  end

  assign prev_choice  = choice_r[lvl_r - JW'(1)];
  assign out_idx_nxt  = found_r ? INDEX_W'(order_r[oidx_r]) : '0;
  assign out_last_nxt = !found_r || ((CW'(oidx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    lvl_nxt       = lvl_r;
    cand_nxt      = cand_r;
    used_nxt      = used_r;
    base_f1_nxt   = base_f1_r;
    base_f2_nxt   = base_f2_r;
    oidx_nxt      = oidx_r;
    out_valid_nxt = out_valid_r;
    job_we        = 1'b0;
    lev_we        = 1'b0;
    lev_wa        = '0;
    lev_wd        = '0;
    choose        = 1'b0;
    save          = 1'b0;
    do_back       = 1'b0;
    out_load      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (count_r < CW'(MAX_JOBS)) begin
            job_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_job) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        best_nxt    = bound_r;
        found_nxt   = 1'b0;
        lvl_nxt     = '0;
        cand_nxt    = '0;
        used_nxt    = '0;
        base_f1_nxt = '0;
        base_f2_nxt = '0;
        lev_we      = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        if (cand_r >= count_r) begin
          do_back = 1'b1;
        end else if (used_r[cand_r[JW-1:0]]) begin
          cand_nxt = cand_r + CW'(1);
        end else begin
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        if (hit) begin
          choose = 1'b1;
          if (!last_lvl) begin
            used_nxt[cand_r[JW-1:0]] = 1'b1;
            lev_we      = 1'b1;
            lev_wa      = lvl_r + JW'(1);
            lev_wd.f1   = f1;
            lev_wd.f2   = f2;
            lvl_nxt     = lvl_r + JW'(1);
            cand_nxt    = '0;
            base_f1_nxt = f1;
            base_f2_nxt = f2;
            state_nxt   = S_RD;
          end else begin
            best_nxt  = f2;
            found_nxt = 1'b1;
            save      = 1'b1;
            do_back   = 1'b1;
          end
        end else begin
          cand_nxt  = cand_r + CW'(1);
          state_nxt = S_RD;
        end
      end
      S_BT: begin
        base_f1_nxt = lev_rd_r.f1;
        base_f2_nxt = lev_rd_r.f2;
        state_nxt   = S_RD;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (out_last_nxt) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            oidx_nxt = oidx_r + JW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step back a level: release the job chosen there and try the next one; at the top level, start streaming results
    if (do_back) begin
      if (lvl_r == '0) begin
        oidx_nxt  = '0;
        state_nxt = S_OUT;
      end else begin
        lvl_nxt               = lvl_r - JW'(1);
        cand_nxt              = CW'(prev_choice) + CW'(1);
        used_nxt[prev_choice] = 1'b0;
        state_nxt             = S_BT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      bound_r     <= BOUND_RESET;
      found_r     <= 1'b0;
      lvl_r       <= '0;
      cand_r      <= '0;
      used_r      <= '0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      found_r     <= found_nxt;
      lvl_r       <= lvl_nxt;
      cand_r      <= cand_nxt;
      used_r      <= used_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bound_r <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    base_f1_r <= base_f1_nxt;
    base_f2_r <= base_f2_nxt;
    if (choose) begin
      choice_r[lvl_r] <= cand_r[JW-1:0];
    end
    if (save) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        order_r[i] <= (JW'(i) == lvl_r) ? cand_r[JW-1:0] : choice_r[i];
      end
    end
    if (out_load) begin
      out_idx_r   <= out_idx_nxt;
      out_span_r  <= best_r;
      out_found_r <= found_r;
      out_ovf_r   <= ovf_r;
      out_last_r  <= out_last_nxt;
    end
  end

  // job memory: written while loading, read in the cycle before evaluation
  always_ff @(posedge clk) begin
    if (job_we) begin
      job_mem[count_r[JW-1:0]] <= '{first: in_first_time, second: in_second_time};
    end
    job_rd_r <= job_mem[cand_r[JW-1:0]];
  end

  // level memory: level 0 cleared at the start, written on descent, read at the level returned to on the way back up
  always_ff @(posedge clk) begin
    if (lev_we) begin
      lev_mem[lev_wa] <= lev_wd;
    end
    lev_rd_r <= lev_mem[lvl_nxt];
  end

endmodule

### sim/tb_flow_shop_backtrack_scheduler.sv
// Self-checking testbench for the two-machine flow shop backtracking scheduler.
`timescale 1ns / 100ps

module tb_flow_shop_backtrack_scheduler;
  import fsbs_pkg::*;

  localparam int MAX_JOBS = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 64;
  // a run holds a few sets of eight jobs, whose exhaustive searches are the longest,
  // so allow several times their worst case
  localparam longint LIMIT_NS = 64'd40_000_000 * 12;

  typedef struct packed {
    logic [INDEX_W-1:0] job;
    logic [SPAN_W-1:0]  span;
    logic               found;
    logic               ovf;
    logic               fin;
  } sched_word_t;

  typedef struct packed {
    bit                is_bound;
    logic [SPAN_W-1:0] bound;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    bit                last;
    bit                known;
    sched_word_t       want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SPAN_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [TIME_W-1:0]  in_first_time;
  logic [TIME_W-1:0]  in_second_time;
  logic               in_last_job;
  logic               out_valid;
  logic               out_ready;
  logic [INDEX_W-1:0] out_job_index;
  logic [SPAN_W-1:0]  out_best_makespan;
  logic               out_found;
  logic               out_overflow;
  logic               out_last_result;

  // shadow of the block state
  logic [TIME_W-1:0] held_first [MAX_JOBS];
  logic [TIME_W-1:0] held_second [MAX_JOBS];
  int unsigned       held_count;
  bit                dropped;
  logic [SPAN_W-1:0] bound_now;
  int unsigned       win_order [MAX_JOBS];
  int unsigned       win_span;

  sched_word_t sched_q [$];
  plan_row_t   plan_rows [$];
  sched_word_t got;
  sched_word_t want;

  bit calm;
  int errors;
  int jobs_sent;
  int sets_done;
  int words_seen;
  int bound_writes;

  flow_shop_backtrack_scheduler #(
    .MAX_JOBS(MAX_JOBS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_first_time     (in_first_time),
    .in_second_time    (in_second_time),
    .in_last_job       (in_last_job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_job_index     (out_job_index),
    .out_best_makespan (out_best_makespan),
    .out_found         (out_found),
    .out_overflow      (out_overflow),
    .out_last_result   (out_last_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Depth-first search over job orders, pruned on strict improvement of the
  // second-machine finish. Fills win_order / win_span; returns 1 if the bound was beaten.
  function automatic bit find_best_order();
    int unsigned pick [MAX_JOBS];
    int unsigned fin1 [MAX_JOBS+1];
    int unsigned fin2 [MAX_JOBS+1];
    int unsigned lvl;
    int unsigned cand;
    int unsigned t1;
    int unsigned t2;
    bit          hit;
    bit          used;
    hit = 1'b0;
    win_span = 32'(bound_now);
    if (held_count == 0) return 1'b0;
    fin1[0] = 0;
    fin2[0] = 0;
    lvl = 0;
    pick[0] = 0;
    while (1'b1) begin
      cand = pick[lvl];
      while (cand < held_count) begin
        used = 1'b0;
        for (int i = 0; i < lvl; i++) if (pick[i] == cand) used = 1'b1;
        if (!used) begin
          t1 = fin1[lvl] + 32'(held_first[cand]);
          t2 = ((t1 > fin2[lvl]) ? t1 : fin2[lvl]) + 32'(held_second[cand]);
          if (t2 < win_span) break;
        end
        cand++;
      end
      if (cand < held_count) begin
        pick[lvl] = cand;
        fin1[lvl+1] = t1;
        fin2[lvl+1] = t2;
        if (lvl + 1 < held_count) begin
          lvl++;
          pick[lvl] = 0;
          continue;
        end
        win_span = t2;
        for (int j = 0; j < held_count; j++) win_order[j] = pick[j];
        hit = 1'b1;
      end
      if (lvl == 0) break;
      // back up one level and try the next candidate there
      lvl--;
      pick[lvl]++;
    end
    return hit;
  endfunction

  task automatic predict_job(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                             input bit last, input bit known, input sched_word_t typed);
    bit          hit;
    sched_word_t w;
    if (held_count < MAX_JOBS) begin
      held_first[held_count] = a;
      held_second[held_count] = b;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      hit = find_best_order();
      if (known) begin
        sched_q.push_back(typed);
      end else if (hit) begin
        for (int j = 0; j < held_count; j++) begin
          w.job   = win_order[j][INDEX_W-1:0];
          w.span  = win_span[SPAN_W-1:0];
          w.found = 1'b1;
          w.ovf   = dropped;
          w.fin   = (j == held_count - 1);
          sched_q.push_back(w);
        end
      end else begin
        w.job   = '0;
        w.span  = bound_now;
        w.found = 1'b0;
        w.ovf   = dropped;
        w.fin   = 1'b1;
        sched_q.push_back(w);
      end
      held_count = 0;
      dropped = 1'b0;
      sets_done++;
    end
  endtask

  task automatic send_job(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                          input bit last, input bit known, input sched_word_t typed);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_first_time  <= a;
    in_second_time <= b;
    in_last_job    <= last;
    do @(posedge clk); while (!in_ready);
    predict_job(a, b, last, known, typed);
    jobs_sent++;
  endtask

  // Write the bound only with the block idle: no word pending, then a short pause.
  task automatic write_bound(input logic [SPAN_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    bound_now = v;
    bound_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_job(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                          input bit last);
    plan_row_t r;
    r = '0;
    r.a = a;
    r.b = b;
    r.last = last;
    plan_rows.push_back(r);
  endtask

  // Last job of a set whose single result word is obvious.
  task automatic plan_known(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                            input int job, input int span, input bit found, input bit ovf);
    plan_row_t r;
    r = '0;
    r.a = a;
    r.b = b;
    r.last = 1'b1;
    r.known = 1'b1;
    r.want = {job[INDEX_W-1:0], span[SPAN_W-1:0], found, ovf, 1'b1};
    plan_rows.push_back(r);
  endtask

  task automatic plan_bound(input logic [SPAN_W-1:0] v);
    plan_row_t r;
    r = '0;
    r.is_bound = 1'b1;
    r.bound = v;
    plan_rows.push_back(r);
  endtask

  task automatic note_miss(input string what);
    errors++;
    if (errors <= 10)
      $display({"%0t %s: expected job %0d span %0d found %b ovf %b last %b,",
                " got job %0d span %0d found %b ovf %b last %b"},
               $time, what, want.job, want.span, want.found, want.ovf, want.fin,
               got.job, got.span, got.found, got.ovf, got.fin);
  endtask

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 9);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      got = {out_job_index, out_best_makespan, out_found, out_overflow, out_last_result};
      if (sched_q.size() == 0) begin
        want = '0;
        note_miss("word with nothing pending");
      end else begin
        want = sched_q.pop_front();
        if (got.job !== want.job || got.span !== want.span || got.found !== want.found ||
            got.ovf !== want.ovf || got.fin !== want.fin)
          note_miss("mismatch");
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_flow_shop_backtrack_scheduler: errors");
    $finish;
  end

  initial begin
    int                size;
    int                mode;
    int                random_jobs;
    int                set_no;
    logic [SPAN_W-1:0] nb;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] eq_a;
    logic [TIME_W-1:0] eq_b;

    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_first_time = '0;
    in_second_time = '0;
    in_last_job = 1'b0;
    out_ready = 1'b0;
    calm = 1'b0;
    held_count = 0;
    dropped = 1'b0;
    bound_now = BOUND_RESET;
    errors = 0;
    jobs_sent = 0;
    sets_done = 0;
    words_seen = 0;
    bound_writes = 0;
    random_jobs = 0;
    set_no = 0;

    // single jobs against the reset bound: zero times, then too slow to beat it
    plan_known(10'd0, 10'd0, 0, 0, 1'b1, 1'b0);
    plan_known(10'd1023, 10'd1023, 0, 1000, 1'b0, 1'b0);
    plan_job(10'd5, 10'd7, 1'b0);
    plan_job(10'd3, 10'd9, 1'b0);
    plan_job(10'd8, 10'd2, 1'b1);
    // identical jobs: the first order found must stay
    plan_job(10'd4, 10'd4, 1'b0);
    plan_job(10'd4, 10'd4, 1'b1);
    // zero bound can never be beaten
    plan_bound(16'd0);
    plan_known(10'd0, 10'd0, 0, 0, 1'b0, 1'b0);
    plan_bound(16'hFFFF);
    plan_job(10'd1023, 10'd0, 1'b0);
    plan_job(10'd0, 10'd1023, 1'b1);
    // full set, then two dropped words; the dropped last still starts the search
    plan_bound(16'd1000);
    for (int j = 0; j < MAX_JOBS; j++) plan_job(10'(300 + j * 37), 10'(200 - j), 1'b0);
    plan_job(10'd1023, 10'd0, 1'b0);
    plan_known(10'd1023, 10'd1023, 0, 1000, 1'b0, 1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_bound)
        write_bound(plan_rows[i].bound);
      else
        send_job(plan_rows[i].a, plan_rows[i].b, plan_rows[i].last,
                 plan_rows[i].known, plan_rows[i].want);
    end

    while (random_jobs < 80) begin
      set_no++;
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: nb = '0;
          1: nb = '1;
          2: nb = SPAN_W'($urandom_range(65535));
          3: nb = SPAN_W'($urandom_range(3000));
          default: nb = SPAN_W'($urandom_range(2500, 800));
        endcase
        write_bound(nb);
      end
      mode = $urandom_range(3);
      if (set_no == 6) begin
        // one full set with a bound near typical makespans
        size = MAX_JOBS;
        mode = 2;
        write_bound(SPAN_W'($urandom_range(6000, 3000)));
      end else if ($urandom_range(9) == 0) begin
        size = MAX_JOBS + $urandom_range(2, 1);
        mode = 2;
        if (bound_now > 3000) write_bound(SPAN_W'($urandom_range(3000)));
      end else begin
        size = $urandom_range(6, 1);
      end
      eq_a = TIME_W'($urandom_range(1023));
      eq_b = TIME_W'($urandom_range(1023));
      for (int k = 0; k < size; k++) begin
        calm = (random_jobs >= 35 && random_jobs < 65);
        case (mode)
          0: begin
            a = TIME_W'($urandom_range(31));
            b = TIME_W'($urandom_range(31));
          end
          1: begin
            a = eq_a;
            b = eq_b;
          end
          default: begin
            a = ($urandom_range(7) == 0) ? {TIME_W{1'($urandom_range(1))}} :
                                           TIME_W'($urandom_range(1023));
            b = ($urandom_range(7) == 0) ? {TIME_W{1'($urandom_range(1))}} :
                                           TIME_W'($urandom_range(1023));
          end
        endcase
        send_job(a, b, k == size - 1, 1'b0, '0);
        random_jobs++;
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += sched_q.size();

    $display("covered %0d jobs in %0d sets, %0d result words, %0d bound writes",
             jobs_sent, sets_done, words_seen, bound_writes);
    if (errors == 0)
      $display("tb_flow_shop_backtrack_scheduler: clean");
    else
      $display("tb_flow_shop_backtrack_scheduler: errors");
    $finish;
  end

endmodule
